FILE: hdl/tbp_pkg.sv
package tbp_pkg;

  // Field widths of the command and result transactions.
  localparam int OP_W       = 3;
  localparam int DIST_W     = 6;
  localparam int ROW_BITS_W = 32;
  localparam int ROW_NUM_W  = 5;

  // Depths of the command queue and the result queue.
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Operation codes as they arrive on the command port.
  typedef enum logic [OP_W-1:0] {
    OP_PEN_UP     = 3'd0,
    OP_PEN_DOWN   = 3'd1,
    OP_TURN_RIGHT = 3'd2,
    OP_TURN_LEFT  = 3'd3,
    OP_MOVE       = 3'd4,
    OP_DUMP       = 3'd5
  } op_t;

  // Headings, clockwise from east.
  typedef enum logic [1:0] {
    HEAD_EAST  = 2'd0,
    HEAD_SOUTH = 2'd1,
    HEAD_WEST  = 2'd2,
    HEAD_NORTH = 2'd3
  } heading_t;

  // Classified command kinds passed from the front end to the engine.
  typedef enum logic [1:0] {
    CMD_PEN  = 2'd0,
    CMD_TURN = 2'd1,
    CMD_MOVE = 2'd2,
    CMD_DUMP = 2'd3
  } cmd_kind_t;

  // For CMD_PEN arg[0] is the new pen state, for CMD_TURN arg[0] set means left,
  // for CMD_MOVE arg is the nonzero distance.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [DIST_W-1:0] arg;
  } cmd_t;

  // One emitted bitmap row.
  typedef struct packed {
    logic [ROW_BITS_W-1:0] row_bits;
    logic [ROW_NUM_W-1:0]  row_number;
    logic                  last_row;
  } out_item_t;

  // Engine states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOAD = 2'd1,
    ST_WALK = 2'd2,
    ST_DUMP = 2'd3
  } eng_state_t;

endpackage

FILE: hdl/tbp_ram.sv
module tbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/tbp_fifo.sv
module tbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : AW'(wr_ptr_r + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : AW'(rd_ptr_r + 1'b1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (do_rd && !do_wr) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; the count guards it.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = slot_r[rd_ptr_r];

endmodule

FILE: hdl/tbp_front.sv
module tbp_front import tbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [DIST_W-1:0] in_distance,
  output logic              in_full,
  input  logic              cmd_pop,
  output cmd_t              cmd,
  output logic              cmd_empty
);

  cmd_t                 cmd_dec;
  logic                 cmd_vld;
  logic                 q_full;
  logic [$bits(cmd_t)-1:0] q_rd_data;

  // Classify the incoming transaction. Unused codes and zero-length moves
  // change nothing, so they are accepted and dropped here.
  always_comb begin
    cmd_dec.kind = CMD_PEN;
    cmd_dec.arg  = '0;
    cmd_vld      = 1'b1;
    case (op_t'(in_operation))
      OP_PEN_UP: begin
        cmd_dec.kind = CMD_PEN;
      end
      OP_PEN_DOWN: begin
        cmd_dec.kind   = CMD_PEN;
        cmd_dec.arg[0] = 1'b1;
      end
      OP_TURN_RIGHT: begin
        cmd_dec.kind = CMD_TURN;
      end
      OP_TURN_LEFT: begin
        cmd_dec.kind   = CMD_TURN;
        cmd_dec.arg[0] = 1'b1;
      end
      OP_MOVE: begin
        cmd_dec.kind = CMD_MOVE;
        cmd_dec.arg  = in_distance;
        cmd_vld      = (in_distance != '0);
      end
      OP_DUMP: begin
        cmd_dec.kind = CMD_DUMP;
      end
      default: begin
        cmd_vld = 1'b0;
      end
    endcase
  end

  // Command queue toward the engine.
  tbp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push && cmd_vld),
    .wr_data (cmd_dec),
    .full    (q_full),
    .rd_en   (cmd_pop),
    .rd_data (q_rd_data),
    .empty   (cmd_empty)
  );

  assign in_full = q_full;
  assign cmd     = cmd_t'(q_rd_data);

endmodule

FILE: hdl/tbp_back.sv
module tbp_back import tbp_pkg::*; #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_empty,
  input  cmd_t                         cmd,
  output logic                         cmd_pop,
  output logic                         ram_wr_en,
  output logic [$clog2(GRID_ROWS)-1:0] ram_wr_addr,
  output logic [GRID_COLS-1:0]         ram_wr_data,
  output logic                         ram_rd_en,
  output logic [$clog2(GRID_ROWS)-1:0] ram_rd_addr,
  input  logic [GRID_COLS-1:0]         ram_rd_data,
  output logic                         out_push,
  output out_item_t                    out_item,
  input  logic                         out_popped
);

  localparam int XW        = $clog2(GRID_COLS);
  localparam int YW        = $clog2(GRID_ROWS);
  localparam int DUMP_ROWS = (GRID_ROWS < 32) ? GRID_ROWS : 32;
  localparam int CW        = $clog2(OUT_DEPTH + 1);
  localparam logic [XW-1:0] X_MAX       = XW'(GRID_COLS - 1);
  localparam logic [YW-1:0] Y_MAX       = YW'(GRID_ROWS - 1);
  localparam logic [YW-1:0] DUMP_LAST   = YW'(DUMP_ROWS - 1);
  localparam logic [CW-1:0] CREDIT_FULL = CW'(OUT_DEPTH);

  eng_state_t           state_r, state_nxt;
  logic [XW-1:0]        pos_x_r, pos_x_nxt;
  logic [YW-1:0]        pos_y_r, pos_y_nxt;
  heading_t             heading_r, heading_nxt;
  logic                 pen_r, pen_nxt;
  logic [DIST_W-1:0]    rem_r, rem_nxt;
  logic [GRID_COLS-1:0] row_buf_r, row_buf_nxt;
  logic                 fresh_r, fresh_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [GRID_ROWS-1:0] valid_r, valid_nxt;
  logic [YW-1:0]        dump_idx_r, dump_idx_nxt;
  logic                 pend_r;
  logic [ROW_NUM_W-1:0] pend_num_r;
  logic                 pend_last_r;
  logic [CW-1:0]        credit_r, credit_nxt;
  logic                 issue;
  logic                 row_moved;
  logic [GRID_COLS-1:0] rd_row, cur_row, row_new;

  // A row never written since reset reads as cleared.
  assign rd_row  = rd_vld_r ? ram_rd_data : '0;
  assign cur_row = fresh_r ? rd_row : row_buf_r;

  // Next state of the turtle engine.
  always_comb begin
    state_nxt    = state_r;
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    heading_nxt  = heading_r;
    pen_nxt      = pen_r;
    rem_nxt      = rem_r;
    row_buf_nxt  = row_buf_r;
    fresh_nxt    = 1'b0;
    dump_idx_nxt = dump_idx_r;
    valid_nxt    = valid_r;
    cmd_pop      = 1'b0;
    ram_wr_en    = 1'b0;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = pos_y_r;
    issue        = 1'b0;
    row_moved    = 1'b0;
    row_new      = cur_row;
    row_new[pos_x_r] = pen_r;

    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_PEN: begin
              pen_nxt = cmd.arg[0];
            end
            CMD_TURN: begin
              heading_nxt = cmd.arg[0] ? heading_t'(2'(heading_r + 2'd3))
                                       : heading_t'(2'(heading_r + 2'd1));
            end
            CMD_MOVE: begin
              rem_nxt   = cmd.arg;
              state_nxt = ST_LOAD;
            end
            CMD_DUMP: begin
              dump_idx_nxt = '0;
              state_nxt    = ST_DUMP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // Fetch the row under the turtle.
      ST_LOAD: begin
        ram_rd_en = 1'b1;
        fresh_nxt = 1'b1;
        state_nxt = ST_WALK;
      end

      // Write the current cell, then step; the row is held locally while
      // the turtle stays on it and written back every cycle.
      ST_WALK: begin
        ram_wr_en          = 1'b1;
        row_buf_nxt        = row_new;
        valid_nxt[pos_y_r] = 1'b1;
        rem_nxt            = DIST_W'(rem_r - 1'b1);
        case (heading_r)
          HEAD_EAST: begin
            if (pos_x_r != X_MAX) pos_x_nxt = XW'(pos_x_r + 1'b1);
          end
          HEAD_SOUTH: begin
            if (pos_y_r != Y_MAX) begin
              pos_y_nxt = YW'(pos_y_r + 1'b1);
              row_moved = 1'b1;
            end
          end
          HEAD_WEST: begin
            if (pos_x_r != '0) pos_x_nxt = XW'(pos_x_r - 1'b1);
          end
          default: begin
            if (pos_y_r != '0) begin
              pos_y_nxt = YW'(pos_y_r - 1'b1);
              row_moved = 1'b1;
            end
          end
        endcase
        if (rem_r == DIST_W'(1)) begin
          state_nxt = ST_IDLE;
        end else if (row_moved) begin
          state_nxt = ST_LOAD;
        end
      end

      // Read one row per cycle while the result queue has room for it.
      ST_DUMP: begin
        if (credit_r != '0) begin
          issue        = 1'b1;
          ram_rd_en    = 1'b1;
          ram_rd_addr  = dump_idx_r;
          dump_idx_nxt = YW'(dump_idx_r + 1'b1);
          if (dump_idx_r == DUMP_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rd_vld_nxt = ram_rd_en ? valid_r[ram_rd_addr] : rd_vld_r;
    credit_nxt = CW'(credit_r - CW'(issue) + CW'(out_popped));
  end

  assign ram_wr_addr = pos_y_r;
  assign ram_wr_data = row_new;

  // The row read last cycle goes to the result queue.
  assign out_push            = pend_r;
  assign out_item.row_bits   = ROW_BITS_W'(rd_row);
  assign out_item.row_number = pend_num_r;
  assign out_item.last_row   = pend_last_r;

  // Control and turtle state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      heading_r  <= HEAD_EAST;
      pen_r      <= 1'b0;
      rem_r      <= '0;
      fresh_r    <= 1'b0;
      rd_vld_r   <= 1'b0;
      valid_r    <= '0;
      dump_idx_r <= '0;
      pend_r     <= 1'b0;
      credit_r   <= CREDIT_FULL;
    end else begin
      state_r    <= state_nxt;
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      heading_r  <= heading_nxt;
      pen_r      <= pen_nxt;
      rem_r      <= rem_nxt;
      fresh_r    <= fresh_nxt;
      rd_vld_r   <= rd_vld_nxt;
      valid_r    <= valid_nxt;
      dump_idx_r <= dump_idx_nxt;
      pend_r     <= issue;
      credit_r   <= credit_nxt;
    end
  end

  // Row data and the tags of the row in flight.
  always_ff @(posedge clk) begin
    row_buf_r <= row_buf_nxt;
    if (issue) begin
      pend_num_r  <= ROW_NUM_W'(dump_idx_r);
      pend_last_r <= (dump_idx_r == DUMP_LAST);
    end
  end

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CREDIT_FULL)
    else $error("result credit exceeds queue depth");

  a_issue_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> credit_r != '0)
    else $error("row read issued without room in the result queue");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en))
    else $error("bitmap read and write in the same cycle");

  a_load_then_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |=> state_r == ST_WALK && fresh_r)
    else $error("row fetch not followed by a walk step");
`endif

endmodule

FILE: hdl/turtle_bitmap_plotter_top.sv
// Turtle plotter on a cleared one-bit bitmap of GRID_ROWS by GRID_COLS cells.
// Commands enter through a four-entry queue, one per cycle while in_full is
// low; unused operation codes and zero-length moves are taken and dropped.
// The engine behind the queue takes each command in its idle state, which is
// all a pen or turn command needs. A move of d cells starts with a row fetch,
// then takes one walk step per cell, with one more row fetch each time the
// turtle changes row before the move is done. A dump reads one row per cycle,
// while the result queue has room, from the bitmap RAM's single read port and
// delivers min(GRID_ROWS, 32) rows, the last one flagged; a stalled reader
// holds it back through a four-entry result queue. After reset the bitmap
// reads as cleared at once: each row carries a valid bit, so no clearing pass
// is needed.
module turtle_bitmap_plotter_top import tbp_pkg::*; #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [DIST_W-1:0]     in_distance,
  output logic                  in_full,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [ROW_BITS_W-1:0] out_row_bits,
  output logic [ROW_NUM_W-1:0]  out_row_number,
  output logic                  out_last_row
);

  localparam int YW = $clog2(GRID_ROWS);

  cmd_t                      cmd;
  logic                      cmd_empty;
  logic                      cmd_pop;
  logic                      ram_wr_en;
  logic [YW-1:0]             ram_wr_addr;
  logic [GRID_COLS-1:0]      ram_wr_data;
  logic                      ram_rd_en;
  logic [YW-1:0]             ram_rd_addr;
  logic [GRID_COLS-1:0]      ram_rd_data;
  logic                      out_push;
  out_item_t                 out_item;
  logic [$bits(out_item_t)-1:0] out_q_data;
  out_item_t                 out_head;
  logic                      out_popped;
  logic                      out_q_full;

  // Command intake and classification.
  tbp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_operation (in_operation),
    .in_distance  (in_distance),
    .in_full      (in_full),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd),
    .cmd_empty    (cmd_empty)
  );

  // Turtle engine.
  tbp_back #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty   (cmd_empty),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_push    (out_push),
    .out_item    (out_item),
    .out_popped  (out_popped)
  );

  // Bitmap storage, one row per word.
  tbp_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result queue; the engine's credit count keeps it from overflowing.
  tbp_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_push),
    .wr_data (out_item),
    .full    (out_q_full),
    .rd_en   (out_pop),
    .rd_data (out_q_data),
    .empty   (out_empty)
  );

  assign out_popped     = out_pop && !out_empty;
  assign out_head       = out_item_t'(out_q_data);
  assign out_row_bits   = out_head.row_bits;
  assign out_row_number = out_head.row_number;
  assign out_last_row   = out_head.last_row;

`ifndef ASSERT_OFF
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_q_full)
    else $error("row pushed into a full result queue");
`endif

endmodule
